// ----- hw/rtl/bmrff_pkg.sv -----
// Shared types and constants for the bitmap rectangle first-fit allocator.
package bmrff_pkg;

  localparam int CELLS_W     = 6;
  localparam int CORNER_W    = 5;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REPORT
  } bmrff_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic mark;
    logic refuse;
    logic emit;
  } bmrff_cmd_t;

  typedef struct packed {
    logic bad_req;
    logic fit;
    logic last_col;
    logic out_free;
  } bmrff_status_t;

endpackage

// ----- hw/rtl/bmrff_ctrl.sv -----
// Controller state machine that sequences the column search and the result handoff.
module bmrff_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid_i,
  output logic                    s_tready_o,
  input  bmrff_pkg::bmrff_status_t status_i,
  output bmrff_pkg::bmrff_cmd_t    cmd_o
);
  import bmrff_pkg::*;

  bmrff_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status_i.bad_req) begin
          cmd_o.refuse = 1'b1;
          state_d      = ST_REPORT;
        end else if (status_i.fit) begin
          cmd_o.mark = 1'b1;
          state_d    = ST_REPORT;
        end else if (status_i.last_col) begin
          cmd_o.refuse = 1'b1;
          state_d      = ST_REPORT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_REPORT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/bmrff_dp.sv -----
// Datapath: occupancy bitmap, column counter, parallel row fit test and output register.
module bmrff_dp #(
  parameter int GRID_SIZE = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bmrff_pkg::bmrff_cmd_t                cmd_i,
  output bmrff_pkg::bmrff_status_t             status_o,
  input  logic [bmrff_pkg::TDATA_IN_W-1:0]     s_tdata_i,
  input  logic                                 m_tready_i,
  output logic                                 m_tvalid_o,
  output logic [bmrff_pkg::TDATA_OUT_W-1:0]    m_tdata_o,
  output logic                                 m_tuser_o
);
  import bmrff_pkg::*;

  localparam int XW    = $clog2(GRID_SIZE);
  localparam int SUM_W = ((XW > CELLS_W) ? XW : CELLS_W) + 1;
  localparam logic [SUM_W-1:0] GridSum = SUM_W'(GRID_SIZE);

  logic [GRID_SIZE-1:0] map_q [GRID_SIZE];
  logic [CELLS_W-1:0]   w_q, h_q;
  logic [XW-1:0]        col_q;
  logic                 res_granted_q;
  logic [CORNER_W-1:0]  res_x_q, res_y_q;
  logic                 out_valid_q;
  logic                 out_granted_q;
  logic [CORNER_W-1:0]  out_x_q, out_y_q;

  logic [SUM_W-1:0]     w_sum, h_sum, col_ext, col_sum, fit_y_ext;
  logic [GRID_SIZE-1:0] col_mask, h_mask, row_ok, fit_at, mark_row;
  logic [XW-1:0]        fit_y;

  assign w_sum   = SUM_W'(w_q);
  assign h_sum   = SUM_W'(h_q);
  assign col_ext = SUM_W'(col_q);
  assign col_sum = col_ext + w_sum;

  assign col_mask = (~({GRID_SIZE{1'b1}} << w_q)) << col_q;
  assign h_mask   = ~({GRID_SIZE{1'b1}} << h_q);

  always_comb begin
    for (int j = 0; j < GRID_SIZE; j++) begin
      row_ok[j] = &(map_q[j] | ~col_mask);
    end
    for (int y = 0; y < GRID_SIZE; y++) begin
      fit_at[y] = (&(row_ok | ~(h_mask << y))) && ((SUM_W'(y) + h_sum) <= GridSum);
    end
    fit_y = '0;
    for (int y = GRID_SIZE - 1; y >= 0; y--) begin
      if (fit_at[y]) begin
        fit_y = XW'(y);
      end
    end
  end

  assign fit_y_ext = SUM_W'(fit_y);

  always_comb begin
    for (int j = 0; j < GRID_SIZE; j++) begin
      mark_row[j] = (SUM_W'(j) >= fit_y_ext) && (SUM_W'(j) < fit_y_ext + h_sum);
    end
  end

  assign status_o.bad_req  = (w_q == '0) || (h_q == '0) || (w_sum > GridSum) ||
                             (h_sum > GridSum);
  assign status_o.fit      = |fit_at;
  assign status_o.last_col = (col_sum == GridSum);
  assign status_o.out_free = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < GRID_SIZE; j++) begin
        map_q[j] <= '1;
      end
    end else if (cmd_i.mark) begin
      for (int j = 0; j < GRID_SIZE; j++) begin
        if (mark_row[j]) begin
          map_q[j] <= map_q[j] & ~col_mask;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q   <= s_tdata_i[CELLS_W-1:0];
      h_q   <= s_tdata_i[2*CELLS_W-1:CELLS_W];
      col_q <= '0;
    end else if (cmd_i.step) begin
      col_q <= col_q + XW'(1);
    end
    if (cmd_i.mark) begin
      res_granted_q <= 1'b1;
      res_x_q       <= col_ext[CORNER_W-1:0];
      res_y_q       <= fit_y_ext[CORNER_W-1:0];
    end else if (cmd_i.refuse) begin
      res_granted_q <= 1'b0;
      res_x_q       <= '0;
      res_y_q       <= '0;
    end
    if (cmd_i.emit) begin
      out_granted_q <= res_granted_q;
      out_x_q       <= res_x_q;
      out_y_q       <= res_y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_granted_q;
  assign m_tdata_o  = TDATA_OUT_W'({out_y_q, out_x_q});

endmodule

// ----- hw/rtl/bitmap_rect_first_fit_allocator_top.sv -----
// Top level of the bitmap rectangle first-fit allocator.
//
// A request transaction on the slave stream carries a rectangle width and
// height in cells. The block searches a GRID_SIZE by GRID_SIZE occupancy
// bitmap column by column, one candidate column per cycle, with all rows of
// that column tested in parallel; the first fitting corner (lowest column,
// then lowest row) is marked used. One result transaction per
// request returns the grant flag on tuser and the corner on tdata, or a zero
// grant with zero corner when nothing fits or the size is out of range.
// The column counter bounds the search; a malformed request takes no column step.
// One request is in work at a time; the next is taken once the result has
// moved into the output register, even while it waits for the receiver.
// A stalled receiver holds the result and the search of the next request
// waits in its report state. Reset marks every cell free.
module bitmap_rect_first_fit_allocator_top #(
  parameter int GRID_SIZE = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [bmrff_pkg::TDATA_IN_W-1:0]     s_axis_tdata_i,  // width_cells, height_cells
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [bmrff_pkg::TDATA_OUT_W-1:0]    m_axis_tdata_o,  // corner_x, corner_y
  output logic                                 m_axis_tuser_o   // granted
);
  import bmrff_pkg::*;

  bmrff_cmd_t    cmd;
  bmrff_status_t status;

  bmrff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bmrff_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_tdata_i  (s_axis_tdata_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ----- hw/rtl/bmrff_checker.sv -----
// Port-level checker for the allocator and its bind to the top level.
module bmrff_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid_i,
  input logic                                 s_axis_tready_o,
  input logic                                 m_axis_tvalid_o,
  input logic                                 m_axis_tready_i,
  input logic [bmrff_pkg::TDATA_OUT_W-1:0]    m_axis_tdata_o,
  input logic                                 m_axis_tuser_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("request taken while another is in work");

  a_refuse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("refused result with nonzero corner");

  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared without a search cycle");

endmodule

bind bitmap_rect_first_fit_allocator_top bmrff_checker u_bmrff_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the bitmap rectangle first-fit allocator top level.
`timescale 1ns / 100ps

module tb_top;
  import bmrff_pkg::*;

  localparam int GRID_CELLS  = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = GRID_CELLS + 32;
  localparam int RANDOM_REQS = 1650;
  localparam int MAX_IDLE    = 17;

  typedef struct {
    logic [CELLS_W-1:0] width;
    logic [CELLS_W-1:0] height;
  } rect_req_t;

  typedef struct {
    logic                granted;
    logic [CORNER_W-1:0] corner_x;
    logic [CORNER_W-1:0] corner_y;
  } rect_grant_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;   // width_cells, height_cells
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;        // corner_x, corner_y
  logic                   m_axis_tuser;        // granted

  logic [GRID_CELLS-1:0] cell_free [GRID_CELLS];
  rect_req_t             pending_reqs[$];
  rect_grant_t           expected_grants[$];
  rect_req_t             req_on_bus;
  rect_grant_t           predicted;
  rect_grant_t           got;
  rect_grant_t           want;
  int                    requests_sent = 0;
  int                    mismatches = 0;
  int                    cycle_count = 0;
  int                    tx_gap = 0;
  int                    rx_stall = 0;
  bit                    tx_offer;
  bit                    tx_idle_on = 1'b1;
  bit                    rx_idle_on = 1'b1;

  bitmap_rect_first_fit_allocator_top #(
    .GRID_SIZE(GRID_CELLS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int r = 0; r < GRID_CELLS; r++) begin
      cell_free[r] = '1;
    end
  end

  // Search column-major for the first free corner, claim its cells.
  function automatic rect_grant_t place_rect(input rect_req_t req);
    rect_grant_t           g;
    logic [GRID_CELLS-1:0] row_mask;
    bit                    clear;
    g.granted  = 1'b0;
    g.corner_x = '0;
    g.corner_y = '0;
    if (req.width == 0 || req.height == 0 || req.width > GRID_CELLS ||
        req.height > GRID_CELLS) begin
      return g;
    end
    for (int x = 0; x + req.width <= GRID_CELLS; x++) begin
      row_mask = GRID_CELLS'((((64'd1 << req.width) - 64'd1) << x));
      for (int y = 0; y + req.height <= GRID_CELLS; y++) begin
        clear = 1'b1;
        for (int j = y; j < y + req.height; j++) begin
          if ((cell_free[j] & row_mask) != row_mask) clear = 1'b0;
        end
        if (clear) begin
          for (int j = y; j < y + req.height; j++) begin
            cell_free[j] = cell_free[j] & ~row_mask;
          end
          g.granted  = 1'b1;
          g.corner_x = CORNER_W'(x);
          g.corner_y = CORNER_W'(y);
          return g;
        end
      end
    end
    return g;
  endfunction

  task automatic add_req(input int w, input int h);
    rect_req_t req;
    req.width  = CELLS_W'(w);
    req.height = CELLS_W'(h);
    pending_reqs = {pending_reqs, req};
  endtask

  // Request driver: hold each request until taken, then idle for a drawn gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      tx_offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = place_rect(req_on_bus);
        expected_grants = {expected_grants, predicted};
        requests_sent++;
        tx_offer = 1'b0;
        if ($urandom_range(0, 63) == 0) tx_idle_on = !tx_idle_on;
        tx_gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (!tx_offer) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (pending_reqs.size() != 0 &&
                     !(requests_sent % 300 == 150 && expected_grants.size() != 0)) begin
          req_on_bus = pending_reqs.pop_front();
          s_axis_tdata <= {{(TDATA_IN_W - 2 * CELLS_W){1'b0}},
                           req_on_bus.height, req_on_bus.width};
          tx_offer = 1'b1;
        end
      end
      s_axis_tvalid <= tx_offer;
    end
  end

  // Result monitor: compare each transaction with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.granted  = m_axis_tuser;
        got.corner_x = m_axis_tdata[CORNER_W-1:0];
        got.corner_y = m_axis_tdata[2*CORNER_W-1:CORNER_W];
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result granted=%b x=%0d y=%0d", $time,
                   got.granted, got.corner_x, got.corner_y);
          mismatches++;
        end else begin
          want = expected_grants.pop_front();
          if (got.granted !== want.granted) begin
            $display("%0t: granted expected %b actual %b", $time, want.granted,
                     got.granted);
            mismatches++;
          end
          if (got.corner_x !== want.corner_x) begin
            $display("%0t: corner_x expected %0d actual %0d", $time, want.corner_x,
                     got.corner_x);
            mismatches++;
          end
          if (got.corner_y !== want.corner_y) begin
            $display("%0t: corner_y expected %0d actual %0d", $time, want.corner_y,
                     got.corner_y);
            mismatches++;
          end
        end
        if ($urandom_range(0, 63) == 0) rx_idle_on = !rx_idle_on;
        rx_stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (rx_stall != 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bitmap_rect_first_fit_allocator_top regression: fail");
      $finish;
    end
  end

  initial begin
    int sel;
    // single cell at origin, full-width row, full-height column
    add_req(1, 1);
    add_req(32, 1);
    add_req(1, 32);
    // zero, oversize and full-grid dimensions
    add_req(0, 1);
    add_req(1, 0);
    add_req(0, 0);
    add_req(33, 1);
    add_req(1, 33);
    add_req(63, 63);
    add_req(32, 33);
    add_req(32, 32);
    // power-of-two and near-full width and height patterns
    add_req(2, 2);
    add_req(4, 8);
    add_req(8, 4);
    add_req(16, 16);
    add_req(31, 2);
    add_req(2, 31);
    // touch right and bottom edges
    add_req(13, 13);
    add_req(3, 1);
    add_req(1, 3);
    add_req(62, 1);
    add_req(1, 48);
    for (int i = 0; i < RANDOM_REQS; i++) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
        add_req($urandom_range(0, 63), $urandom_range(0, 63));
      end else if (sel == 1) begin
        add_req($urandom_range(1, 32), $urandom_range(1, 32));
      end else if (sel == 2) begin
        add_req($urandom_range(1, 32), $urandom_range(1, 3));
      end else if (sel == 3) begin
        add_req($urandom_range(1, 3), $urandom_range(1, 32));
      end else begin
        add_req($urandom_range(1, 4), $urandom_range(1, 4));
      end
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("bitmap_rect_first_fit_allocator_top regression: pass");
    end else begin
      $display("bitmap_rect_first_fit_allocator_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bmrff_pkg.sv
hw/rtl/bmrff_ctrl.sv
hw/rtl/bmrff_dp.sv
hw/rtl/bitmap_rect_first_fit_allocator_top.sv
hw/rtl/bmrff_checker.sv
tb/tb_top.sv
